// ===== rtl/first_fit_hole_allocator_assert.svh =====
// Assertion macros for the hole allocator.
`ifndef FIRST_FIT_HOLE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HOLE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FHA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");
`define FHA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");
`else
`define FHA_ASSERT_SAME(lbl, ante, cons)
`define FHA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/fha_pkg.sv =====
`default_nettype none
package fha_pkg;
	localparam int FHA_NUM_ENTRIES = 128;
	// granule must be a power of two
	localparam int FHA_GRANULE = 8;
	localparam int FHA_HEADER = 8;
	localparam int FHA_IW_MAX = 11;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_LEAK  = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;

	typedef struct packed {
		logic        mode;
		logic [31:0] req_addr;
		logic [31:0] req_size;
	} fha_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] block_addr;
		logic [31:0] block_length;
	} fha_out_t;

	typedef struct packed {
		logic [FHA_IW_MAX-1:0] ra;
		logic                  b_we;
		logic                  l_we;
		logic                  n_we;
		logic [FHA_IW_MAX-1:0] bl_wa;
		logic [FHA_IW_MAX-1:0] n_wa;
		logic [31:0]           b_wd;
		logic [31:0]           l_wd;
		logic [FHA_IW_MAX-1:0] n_wd;
	} fha_cmd_t;

	typedef struct packed {
		logic [31:0]           base;
		logic [31:0]           len;
		logic [FHA_IW_MAX-1:0] next;
	} fha_rd_t;
endpackage
`default_nettype wire

// ===== rtl/first_fit_hole_allocator.sv =====
// A rejected allocation or a zero-length free finishes straight from idle; any other request
// walks the hole list, reading and then evaluating each hole that it visits, before it finishes.
// Only one request is handled at a time; the list walk goes through the single-read-port entry
// table. start may be taken in the cycle that done is high.
// Reset: arst_n clears the hole list (empty) and the spare list (all entries linked).
// The result is shown for one cycle with done; the receiver cannot stall.
`default_nettype none
`include "first_fit_hole_allocator_assert.svh"
module first_fit_hole_allocator import fha_pkg::*; #(
	parameter int NUM_ENTRIES   = FHA_NUM_ENTRIES,
	parameter int GRANULE_BYTES = FHA_GRANULE,
	parameter int HEADER_BYTES  = FHA_HEADER
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire fha_in_t req,
	output logic         busy,
	output logic         done,
	output fha_out_t     res
);
	localparam int IW = $clog2(NUM_ENTRIES + 1);
	localparam logic [IW-1:0] NIL = IW'(NUM_ENTRIES);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_READ   = 4'd1;
	localparam logic [3:0] S_EVAL   = 4'd2;
	localparam logic [3:0] S_POST   = 4'd3;
	localparam logic [3:0] S_MREAD  = 4'd4;
	localparam logic [3:0] S_MEVAL  = 4'd5;
	localparam logic [3:0] S_SPREAD = 4'd6;
	localparam logic [3:0] S_SPEVAL = 4'd7;
	localparam logic [3:0] S_LINK   = 4'd8;

	logic [3:0]    state_q;
	logic          mode_q;
	logic [31:0]   addr_q, size_q, b_q, l_q, htop_q, nlen_q;
	logic [IW-1:0] cur_q, prev_q, nx_q, spare_q, used_q, n_q, pa_q, pd_q;
	fha_out_t      res_q;
	logic          done_q;

	fha_cmd_t      cmd;
	fha_rd_t       rd;
	logic [31:0]   rb, rl, rsum;
	logic [IW-1:0] rn;
	logic [32:0]   want;
	logic          fit, empty, adj, brk, mhit;

	fha_table #(.NUM_ENTRIES(NUM_ENTRIES)) u_table (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rd(rd));

	assign rb    = rd.base;
	assign rl    = rd.len;
	assign rn    = rd.next[IW-1:0];
	assign rsum  = rb + rl;
	assign fit   = rl >= size_q;
	assign empty = rl == size_q;
	assign adj   = rsum == addr_q;
	assign brk   = rb > addr_q;
	assign mhit  = htop_q == rb;
	assign want  = ({1'b0, req.req_size} + 33'(GRANULE_BYTES) + 33'(HEADER_BYTES))
		& ~33'(GRANULE_BYTES - 1);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_READ:   cmd.ra = FHA_IW_MAX'(cur_q);
			S_MREAD:  cmd.ra = FHA_IW_MAX'(nx_q);
			S_SPREAD: cmd.ra = FHA_IW_MAX'(spare_q);
			S_EVAL: begin
				cmd.bl_wa = FHA_IW_MAX'(cur_q);
				if (mode_q == MODE_ALLOC) begin
					if (fit) begin
						cmd.b_we = 1'b1;
						cmd.l_we = 1'b1;
						cmd.b_wd = rb + size_q;
						cmd.l_wd = rl - size_q;
						if (empty) begin
							cmd.n_we = 1'b1;
							if (prev_q != NIL) begin
								cmd.n_wa = FHA_IW_MAX'(prev_q);
								cmd.n_wd = FHA_IW_MAX'(rn);
							end else begin
								cmd.n_wa = FHA_IW_MAX'(cur_q);
								cmd.n_wd = FHA_IW_MAX'(spare_q);
							end
						end
					end
				end else if (adj) begin
					cmd.l_we = 1'b1;
					cmd.l_wd = rl + size_q;
				end
			end
			S_POST: begin
				if (cur_q != NIL && (addr_q + size_q) == b_q) begin
					cmd.bl_wa = FHA_IW_MAX'(cur_q);
					cmd.b_we  = 1'b1;
					cmd.l_we  = 1'b1;
					cmd.b_wd  = b_q - size_q;
					cmd.l_wd  = l_q + size_q;
				end
			end
			S_SPEVAL: begin
				cmd.bl_wa = FHA_IW_MAX'(spare_q);
				cmd.b_we  = 1'b1;
				cmd.l_we  = 1'b1;
				cmd.b_wd  = addr_q;
				cmd.l_wd  = size_q;
				cmd.n_we  = 1'b1;
				cmd.n_wa  = FHA_IW_MAX'(spare_q);
				cmd.n_wd  = FHA_IW_MAX'(cur_q);
			end
			S_MEVAL: begin
				if (mhit) begin
					cmd.bl_wa = FHA_IW_MAX'(cur_q);
					cmd.l_we  = 1'b1;
					cmd.l_wd  = nlen_q + rl;
					cmd.n_we  = 1'b1;
					cmd.n_wa  = FHA_IW_MAX'(cur_q);
					cmd.n_wd  = FHA_IW_MAX'(rn);
				end
			end
			S_LINK: begin
				cmd.n_we = 1'b1;
				cmd.n_wa = FHA_IW_MAX'(pa_q);
				cmd.n_wd = FHA_IW_MAX'(pd_q);
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			spare_q <= '0;
			used_q  <= NIL;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						res_q  <= '{status: ST_OK, block_addr: '0, block_length: '0};
						mode_q <= req.mode;
						addr_q <= req.req_addr;
						cur_q  <= used_q;
						prev_q <= NIL;
						n_q    <= '0;
						if (req.mode == MODE_ALLOC) begin
							size_q <= want[31:0];
							if (want[32]) begin
								res_q.status <= ST_NOFIT;
								done_q       <= 1'b1;
							end else begin
								state_q <= S_READ;
							end
						end else begin
							size_q <= req.req_size;
							if (req.req_size == '0) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_READ;
							end
						end
					end
				end
				S_READ: begin
					if (cur_q == NIL || n_q == NIL) begin
						if (mode_q == MODE_ALLOC) begin
							res_q.status <= ST_NOFIT;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							cur_q   <= NIL;
							state_q <= S_POST;
						end
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					b_q <= rb;
					l_q <= rl;
					if (mode_q == MODE_ALLOC && fit) begin
						res_q.block_addr   <= rb;
						res_q.block_length <= size_q;
						if (empty) begin
							spare_q <= cur_q;
							if (prev_q != NIL) begin
								pa_q    <= cur_q;
								pd_q    <= spare_q;
								state_q <= S_LINK;
							end else begin
								used_q  <= rn;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (mode_q != MODE_ALLOC && adj) begin
						nlen_q <= rl + size_q;
						htop_q <= rsum + size_q;
						nx_q   <= rn;
						if (rn != NIL) begin
							state_q <= S_MREAD;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (mode_q != MODE_ALLOC && brk) begin
						state_q <= S_POST;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= rn;
						n_q     <= n_q + IW'(1);
						state_q <= S_READ;
					end
				end
				S_POST: begin
					if (cur_q != NIL && (addr_q + size_q) == b_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (spare_q == NIL) begin
						res_q.status <= ST_LEAK;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_SPREAD;
					end
				end
				S_SPREAD: state_q <= S_SPEVAL;
				S_SPEVAL: begin
					spare_q <= rn;
					if (prev_q != NIL) begin
						pa_q    <= prev_q;
						pd_q    <= spare_q;
						state_q <= S_LINK;
					end else begin
						used_q  <= spare_q;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MREAD: state_q <= S_MEVAL;
				S_MEVAL: begin
					if (mhit) begin
						pa_q    <= nx_q;
						pd_q    <= spare_q;
						spare_q <= nx_q;
						state_q <= S_LINK;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LINK: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign res  = res_q;

	`FHA_ASSERT_SAME(a_done_idle, done, !busy)
	`FHA_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done)
	`FHA_ASSERT_SAME(a_fail_zero, done && res.status != ST_OK,
		res.block_addr == '0 && res.block_length == '0)
	`FHA_ASSERT_SAME(a_status_code, done, res.status != 2'd3)
endmodule
`default_nettype wire

// ===== rtl/fha_ram.sv =====
`default_nettype none
module fha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/fha_table.sv =====
`default_nettype none
module fha_table import fha_pkg::*; #(
	parameter int NUM_ENTRIES = FHA_NUM_ENTRIES
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire fha_cmd_t cmd,
	output fha_rd_t       rd
);
	localparam int AW = $clog2(NUM_ENTRIES);
	localparam int IW = $clog2(NUM_ENTRIES + 1);

	logic [NUM_ENTRIES-1:0] nv_q;
	logic                   nvr_q;
	logic [AW-1:0]          ridx_q;
	logic [31:0]            base_rd;
	logic [31:0]            len_rd;
	logic [IW-1:0]          next_rd;
	logic [IW-1:0]          next_eff;

	fha_ram #(.WIDTH(32), .DEPTH(NUM_ENTRIES)) u_base (
		.clk(clk), .we(cmd.b_we), .waddr(cmd.bl_wa[AW-1:0]), .wdata(cmd.b_wd),
		.raddr(cmd.ra[AW-1:0]), .rdata(base_rd));
	fha_ram #(.WIDTH(32), .DEPTH(NUM_ENTRIES)) u_len (
		.clk(clk), .we(cmd.l_we), .waddr(cmd.bl_wa[AW-1:0]), .wdata(cmd.l_wd),
		.raddr(cmd.ra[AW-1:0]), .rdata(len_rd));
	fha_ram #(.WIDTH(IW), .DEPTH(NUM_ENTRIES)) u_next (
		.clk(clk), .we(cmd.n_we), .waddr(cmd.n_wa[AW-1:0]), .wdata(cmd.n_wd[IW-1:0]),
		.raddr(cmd.ra[AW-1:0]), .rdata(next_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= '0;
		end else if (cmd.n_we) begin
			nv_q[cmd.n_wa[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		nvr_q  <= nv_q[cmd.ra[AW-1:0]];
		ridx_q <= cmd.ra[AW-1:0];
	end

	// unwritten link points at the following entry
	assign next_eff = nvr_q ? next_rd : IW'(ridx_q) + IW'(1);
	assign rd = '{base: base_rd, len: len_rd, next: FHA_IW_MAX'(next_eff)};
endmodule
`default_nettype wire

// ===== test/tb_first_fit_hole_allocator.sv =====
`timescale 1ns / 1ps
module tb_first_fit_hole_allocator;
	import fha_pkg::*;

	localparam int NE = FHA_NUM_ENTRIES;
	localparam int GR = FHA_GRANULE;
	localparam int HD = FHA_HEADER;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic start;
	fha_in_t req;
	logic busy;
	logic done;
	fha_out_t res;

	first_fit_hole_allocator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .res(res)
	);

	logic [31:0] hole_base [NE];
	logic [31:0] hole_len [NE];
	int hole_next [NE];
	int hole_head;
	int spare_head;

	fha_out_t pending_results [$];
	int failures;
	longint cycles;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic fha_out_t predict_alloc(logic [31:0] sz);
		fha_out_t r;
		logic [33:0] want;
		logic [31:0] size;
		int prv;
		int cur;
		int n;
		r = '{ST_NOFIT, 32'd0, 32'd0};
		want = {2'b0, sz} + 34'(GR) + 34'(HD);
		want = want - (want % 34'(GR));
		if (want > 34'hFFFF_FFFF)
			return r;
		size = want[31:0];
		prv = NE;
		cur = hole_head;
		for (n = 0; n < NE && cur < NE; n++) begin
			if (hole_len[cur] >= size) begin
				r = '{ST_OK, hole_base[cur], size};
				hole_base[cur] = hole_base[cur] + size;
				hole_len[cur] = hole_len[cur] - size;
				if (hole_len[cur] == 0) begin
					if (prv < NE)
						hole_next[prv] = hole_next[cur];
					else
						hole_head = hole_next[cur];
					hole_next[cur] = spare_head;
					spare_head = cur;
				end
				return r;
			end
			prv = cur;
			cur = hole_next[cur];
		end
		return r;
	endfunction

	function automatic fha_out_t predict_free(logic [31:0] addr, logic [31:0] sz);
		fha_out_t r;
		logic [31:0] top;
		logic [31:0] htop;
		int prv;
		int cur;
		int n;
		int nx;
		int fresh;
		r = '{ST_OK, 32'd0, 32'd0};
		top = addr + sz;
		if (sz == 0)
			return r;
		prv = NE;
		cur = hole_head;
		for (n = 0; n < NE && cur < NE; n++) begin
			if (hole_base[cur] + hole_len[cur] == addr) begin
				nx = hole_next[cur];
				hole_len[cur] = hole_len[cur] + sz;
				htop = hole_base[cur] + hole_len[cur];
				if (nx < NE && htop == hole_base[nx]) begin
					hole_len[cur] = hole_len[cur] + hole_len[nx];
					hole_next[cur] = hole_next[nx];
					hole_next[nx] = spare_head;
					spare_head = nx;
				end
				return r;
			end
			if (hole_base[cur] > addr)
				break;
			prv = cur;
			cur = hole_next[cur];
		end
		if (n >= NE)
			cur = NE;
		if (cur < NE && top == hole_base[cur]) begin
			hole_base[cur] = hole_base[cur] - sz;
			hole_len[cur] = hole_len[cur] + sz;
			return r;
		end
		if (spare_head >= NE) begin
			r.status = ST_LEAK;
			return r;
		end
		fresh = spare_head;
		spare_head = hole_next[fresh];
		hole_base[fresh] = addr;
		hole_len[fresh] = sz;
		hole_next[fresh] = cur;
		if (prv < NE)
			hole_next[prv] = fresh;
		else
			hole_head = fresh;
		return r;
	endfunction

	task automatic send_request(logic m, logic [31:0] a, logic [31:0] s);
		fha_in_t it;
		int gap;
		gap = $urandom_range(0, 7);
		if (gap != 0) begin
			start <= 1'b0;
			req <= fha_in_t'({1'b0, $urandom, $urandom});
			repeat (gap) @(posedge clk);
		end
		it = '{m, a, s};
		start <= 1'b1;
		req <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (m == MODE_ALLOC)
			pending_results.push_back(predict_alloc(s));
		else
			pending_results.push_back(predict_free(a, s));
	endtask

	task automatic idle_cycles(int n);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				failures++;
			end else begin
				fha_out_t e;
				e = pending_results.pop_front();
				if (res.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, res.status);
					failures++;
				end
				if (res.block_addr !== e.block_addr) begin
					$error("block_addr exp %h got %h", e.block_addr, res.block_addr);
					failures++;
				end
				if (res.block_length !== e.block_length) begin
					$error("block_length exp %h got %h", e.block_length, res.block_length);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic test_directed();
		send_request(MODE_ALLOC, 32'd0, 32'd0);
		send_request(~MODE_ALLOC, 32'h1000, 32'd0);
		send_request(~MODE_ALLOC, 32'h1000, 32'h1000);
		send_request(MODE_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
		send_request(MODE_ALLOC, 32'd0, 32'hFFFF_FFFF);
		send_request(MODE_ALLOC, 32'd0, 32'hFFFF_FFE7);
		send_request(MODE_ALLOC, 32'd0, 32'd0);
		send_request(MODE_ALLOC, 32'd0, 32'h0FF0);
		send_request(MODE_ALLOC, 32'd0, 32'd5);
		send_request(~MODE_ALLOC, 32'h3000, 32'h100);
		send_request(~MODE_ALLOC, 32'h3100, 32'h100);
		send_request(~MODE_ALLOC, 32'h2F00, 32'h100);
		send_request(~MODE_ALLOC, 32'h3400, 32'h100);
		send_request(~MODE_ALLOC, 32'h3200, 32'h200);
		send_request(~MODE_ALLOC, 32'hFFFF_FF00, 32'h200);
		send_request(~MODE_ALLOC, 32'h0000_0100, 32'hFFFF_FFFF);
		send_request(MODE_ALLOC, 32'd0, 32'h7FFF_FFFF);
		send_request(MODE_ALLOC, 32'd0, 32'h10);
	endtask

	task automatic test_leak();
		int i;
		for (i = 0; i < NE + 4; i++)
			send_request(~MODE_ALLOC, 32'h8000_0000 + i * 32'h40, 32'h10);
		for (i = 0; i < 40; i++)
			send_request(MODE_ALLOC, 32'd0, $urandom_range(0, 8));
	endtask

	task automatic test_random();
		int i;
		logic [31:0] a;
		logic [31:0] s;
		int k;
		for (i = 0; i < 1350; i++) begin
			k = $urandom_range(0, 9);
			a = $urandom_range(0, 255) * 32'h40 + 32'h4000_0000;
			s = $urandom_range(1, 8) * 32'h8;
			case (k)
				0: send_request(MODE_ALLOC, $urandom, $urandom);
				1: send_request(~MODE_ALLOC, $urandom, $urandom);
				2, 3, 4: send_request(MODE_ALLOC, $urandom, $urandom_range(0, 96));
				5: send_request(~MODE_ALLOC, a, s);
				6: send_request(~MODE_ALLOC, a, 32'h40);
				7: send_request(~MODE_ALLOC, a + 32'h40 - s, s);
				8: send_request(~MODE_ALLOC, a, $urandom_range(0, 1) ? 32'd0 : s);
				default: send_request(MODE_ALLOC, $urandom, $urandom_range(0, 64) * 32'h40);
			endcase
			if ($urandom_range(0, 9) == 0)
				idle_cycles($urandom_range(0, 7));
		end
	endtask

	initial begin
		int i;
		failures = 0;
		cycles = 0;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		for (i = 0; i < NE; i++) begin
			hole_base[i] = '0;
			hole_len[i] = '0;
			hole_next[i] = i + 1;
		end
		hole_head = NE;
		spare_head = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_leak();
		test_random();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * NE + 10) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
